[rtl/core/v4n_pkg.sv]
// Shared types and constants for the four-component vector normalizer.
package v4n_pkg;

  // Component width. Input bits above it are ignored.
  localparam int CompBits = 32;
  localparam int Lanes = 4;

  // Pipeline depths.
  localparam int FrontStages = 4;
  localparam int SqrtCells = 33;
  localparam int DivCells = 31;
  localparam int CoreStages = FrontStages + SqrtCells + DivCells;

  // Component magnitudes and signs that travel beside the arithmetic.
  typedef struct packed {
    logic [Lanes-1:0][31:0] mag;
    logic [Lanes-1:0]       neg;
  } side_t;

  // Front end result: the exact sum of squares, padded to an even width.
  typedef struct packed {
    logic [65:0] sum;
    side_t       side;
  } front_out_t;

  // One square-root digit step.
  typedef struct packed {
    logic [65:0] s;
    logic [35:0] rem;
    logic [32:0] root;
  } sqrt_stage_t;

  // One divider quotient-bit step.
  typedef struct packed {
    logic [33:0] rem;
    logic [30:0] q;
    logic [30:0] nb;
    logic [32:0] d;
  } div_stage_t;

  // Data that rides beside the divider chain.
  typedef struct packed {
    logic [Lanes-1:0] neg;
    logic [32:0]      root;
  } dside_t;

endpackage

[rtl/core/vector4_normalize.sv]
// Top level of the four-component fixed-point vector normalizer.
// One vector transfer is accepted every cycle while in_stall is low, each giving one
// result: the front end registers magnitudes, squares, pair sums and the exact sum of
// squares, 33 square-root cells settle the length and 31 divider cells per component
// the Q2.30 quotient, one bit per cell, then the output register. The whole pipeline
// holds while a result waits under out_stall, and in_stall follows it.
module vector4_normalize (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_comp_x,
  input  logic [31:0]        in_comp_y,
  input  logic [31:0]        in_comp_z,
  input  logic [31:0]        in_comp_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_unit_x,
  output logic signed [31:0] out_unit_y,
  output logic signed [31:0] out_unit_z,
  output logic signed [31:0] out_unit_w,
  output logic [32:0]        out_magnitude,
  output logic               out_zero_vector
);

  logic                   en;
  logic [v4n_pkg::CoreStages-1:0] vld_r;
  logic                   out_valid_r;
  v4n_pkg::front_out_t    fo;
  v4n_pkg::sqrt_stage_t   sq_st [0:v4n_pkg::SqrtCells];
  v4n_pkg::side_t         side_sq_r [0:v4n_pkg::SqrtCells-1];
  v4n_pkg::div_stage_t    dv_st [0:v4n_pkg::Lanes-1][0:v4n_pkg::DivCells];
  v4n_pkg::dside_t        dside_r [0:v4n_pkg::DivCells-1];
  logic [v4n_pkg::Lanes-1:0][31:0] unit_nxt;
  logic [v4n_pkg::Lanes-1:0][31:0] unit_r;
  logic [32:0]            mag_r;
  logic                   zero_nxt;
  logic                   zero_r;
  logic [31:0]            uq;

  // The pipeline moves unless a finished result is held back.
  assign en = !(out_valid_r && out_stall);
  assign in_stall = !en;

  v4n_front u_front (
    .clk    (clk),
    .en     (en),
    .comp_x (in_comp_x),
    .comp_y (in_comp_y),
    .comp_z (in_comp_z),
    .comp_w (in_comp_w),
    .fo     (fo)
  );

  // Square-root chain, with magnitudes and signs riding alongside.
  assign sq_st[0] = '{s: fo.sum, rem: '0, root: '0};

  for (genvar k = 0; k < v4n_pkg::SqrtCells; k++) begin : g_sqrt
    v4n_sqrt_cell u_cell (
      .clk (clk),
      .en  (en),
      .si  (sq_st[k]),
      .so  (sq_st[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_sq_r[0] <= fo.side;
      for (int k = 1; k < v4n_pkg::SqrtCells; k++) begin
        side_sq_r[k] <= side_sq_r[k-1];
      end
    end
  end

  // Divider chains, one per component, all dividing by the length.
  for (genvar l = 0; l < v4n_pkg::Lanes; l++) begin : g_lane
    assign dv_st[l][0] = '{
      rem:  {3'b000, side_sq_r[v4n_pkg::SqrtCells-1].mag[l][31:1]},
      q:    '0,
      nb:   {side_sq_r[v4n_pkg::SqrtCells-1].mag[l][0], 30'd0},
      d:    sq_st[v4n_pkg::SqrtCells].root
    };
    for (genvar k = 0; k < v4n_pkg::DivCells; k++) begin : g_div
      v4n_div_cell u_cell (
        .clk  (clk),
        .en   (en),
        .di   (dv_st[l][k]),
        .dout (dv_st[l][k+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dside_r[0] <= '{neg: side_sq_r[v4n_pkg::SqrtCells-1].neg,
                      root: sq_st[v4n_pkg::SqrtCells].root};
      for (int k = 1; k < v4n_pkg::DivCells; k++) begin
        dside_r[k] <= dside_r[k-1];
      end
    end
  end

  // Restore the signs and clear everything for a zero vector.
  always_comb begin
    uq = '0;
    zero_nxt = (dside_r[v4n_pkg::DivCells-1].root == 33'd0);
    for (int l = 0; l < v4n_pkg::Lanes; l++) begin
      uq = {1'b0, dv_st[l][v4n_pkg::DivCells].q};
      if (zero_nxt) begin
        unit_nxt[l] = '0;
      end else if (dside_r[v4n_pkg::DivCells-1].neg[l]) begin
        unit_nxt[l] = ~uq + 32'd1;
      end else begin
        unit_nxt[l] = uq;
      end
    end
  end

  // Valid bits for each stage and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[v4n_pkg::CoreStages-2:0], in_valid};
      out_valid_r <= vld_r[v4n_pkg::CoreStages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_r <= unit_nxt;
      mag_r  <= dside_r[v4n_pkg::DivCells-1].root;
      zero_r <= zero_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_unit_x = unit_r[0];
  assign out_unit_y = unit_r[1];
  assign out_unit_z = unit_r[2];
  assign out_unit_w = unit_r[3];
  assign out_magnitude = mag_r;
  assign out_zero_vector = zero_r;

  // A zero vector clears every unit component.
  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && zero_r |-> unit_r == '0)
    else $error("zero vector with nonzero unit components");

  // The length never exceeds two to the thirty-second.
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> mag_r <= 33'h1_0000_0000)
    else $error("magnitude out of range");

  // The x unit component stays within plus and minus one.
  a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(unit_r[0]) <= 32'sh4000_0000) &&
                    ($signed(unit_r[0]) >= -32'sh4000_0000))
    else $error("unit component out of range");

  // A held result keeps the whole pipeline frozen.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(vld_r))
    else $error("pipeline moved while the result was held");

endmodule

[rtl/core/v4n_front.sv]
// Front end: component magnitudes, squares and the exact sum of squares.
module v4n_front (
  input  logic                   clk,
  input  logic                   en,
  input  logic [31:0]            comp_x,
  input  logic [31:0]            comp_y,
  input  logic [31:0]            comp_z,
  input  logic [31:0]            comp_w,
  output v4n_pkg::front_out_t    fo
);

  logic [v4n_pkg::Lanes-1:0][31:0]        comp;
  logic [v4n_pkg::Lanes-1:0][v4n_pkg::CompBits-1:0] raw;
  logic [v4n_pkg::Lanes-1:0][v4n_pkg::CompBits-1:0] absv;
  v4n_pkg::side_t                         s1_nxt;
  v4n_pkg::side_t                         s1_r;
  v4n_pkg::side_t                         s2_r;
  v4n_pkg::side_t                         s3_r;
  v4n_pkg::side_t                         s4_r;
  logic [v4n_pkg::Lanes-1:0][63:0]        sq_nxt;
  logic [v4n_pkg::Lanes-1:0][63:0]        sq_r;
  logic [64:0]                            pa_nxt;
  logic [64:0]                            pb_nxt;
  logic [64:0]                            pa_r;
  logic [64:0]                            pb_r;
  logic [65:0]                            sum_nxt;
  logic [65:0]                            sum_r;

  assign comp = {comp_w, comp_z, comp_y, comp_x};

  // Sign and magnitude of each component taken from its low bits.
  always_comb begin
    for (int i = 0; i < v4n_pkg::Lanes; i++) begin
      raw[i] = comp[i][v4n_pkg::CompBits-1:0];
      absv[i] = raw[i][v4n_pkg::CompBits-1] ? (~raw[i] + 1'b1) : raw[i];
      s1_nxt.neg[i] = raw[i][v4n_pkg::CompBits-1];
      s1_nxt.mag[i] = 32'(absv[i]);
    end
  end

  // One multiplier per lane.
  always_comb begin
    for (int i = 0; i < v4n_pkg::Lanes; i++) begin
      sq_nxt[i] = s1_r.mag[i] * s1_r.mag[i];
    end
  end

  // Two pair sums, then the final sum.
  assign pa_nxt = {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
  assign pb_nxt = {1'b0, sq_r[2]} + {1'b0, sq_r[3]};
  assign sum_nxt = {1'b0, pa_r} + {1'b0, pb_r};

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      sq_r  <= sq_nxt;
      s2_r  <= s1_r;
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      s3_r  <= s2_r;
      sum_r <= sum_nxt;
      s4_r  <= s3_r;
    end
  end

  assign fo.sum = sum_r;
  assign fo.side = s4_r;

endmodule

[rtl/core/v4n_sqrt_cell.sv]
// Square-root cell: takes two radicand bits and settles one root bit.
module v4n_sqrt_cell (
  input  logic                 clk,
  input  logic                 en,
  input  v4n_pkg::sqrt_stage_t si,
  output v4n_pkg::sqrt_stage_t so
);

  logic [35:0]          rem_sh;
  logic [35:0]          trial;
  v4n_pkg::sqrt_stage_t so_nxt;
  v4n_pkg::sqrt_stage_t so_r;

  // Bring in the next digit pair and try the root bit as one.
  always_comb begin
    rem_sh = {si.rem[33:0], si.s[65:64]};
    trial = {1'b0, si.root, 2'b01};
    so_nxt.s = {si.s[63:0], 2'b00};
    if (rem_sh >= trial) begin
      so_nxt.rem = rem_sh - trial;
      so_nxt.root = {si.root[31:0], 1'b1};
    end else begin
      so_nxt.rem = rem_sh;
      so_nxt.root = {si.root[31:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      so_r <= so_nxt;
    end
  end

  assign so = so_r;

endmodule

[rtl/core/v4n_div_cell.sv]
// Divider cell: one restoring step that settles one quotient bit.
module v4n_div_cell (
  input  logic                clk,
  input  logic                en,
  input  v4n_pkg::div_stage_t di,
  output v4n_pkg::div_stage_t dout
);

  logic [33:0]         rem_sh;
  v4n_pkg::div_stage_t do_nxt;
  v4n_pkg::div_stage_t do_r;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    rem_sh = {di.rem[32:0], di.nb[30]};
    do_nxt.nb = {di.nb[29:0], 1'b0};
    do_nxt.d = di.d;
    if (rem_sh >= {1'b0, di.d}) begin
      do_nxt.rem = rem_sh - {1'b0, di.d};
      do_nxt.q = {di.q[29:0], 1'b1};
    end else begin
      do_nxt.rem = rem_sh;
      do_nxt.q = {di.q[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      do_r <= do_nxt;
    end
  end

  assign dout = do_r;

endmodule
